### hdl/worst_fit_block_allocator_macros.svh
// Assertion macros for the worst-fit block allocator
`ifndef WORST_FIT_BLOCK_ALLOCATOR_MACROS_SVH
`define WORST_FIT_BLOCK_ALLOCATOR_MACROS_SVH

// check cons in the same cycle as ante
`define WFBA_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// check cons in the cycle after ante
`define WFBA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hdl/wfba_pkg.sv
package wfba_pkg;

	localparam int MAX_BLOCKS_DEF = 16;
	localparam int SIZE_BITS_DEF  = 16;
	localparam int AMOUNT_W       = 16;
	localparam int NUM_W          = 5;
	localparam int STATUS_W       = 2;

	typedef enum logic {
		OP_LOAD    = 1'b0,
		OP_REQUEST = 1'b1
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_ALLOCATED = 2'd0,
		ST_NO_FIT    = 2'd1,
		ST_LOADED    = 2'd2,
		ST_FULL      = 2'd3
	} status_t;

endpackage

### hdl/wfba_ram.sv
module wfba_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    addr,
	input  logic [WIDTH-1:0] wdata,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

### hdl/worst_fit_block_allocator.sv
// Worst-fit block allocator. Raise start with op and amount while busy is low.
// A load (op 0) stores the next block size: busy stays low, and the result
// appears with done in the following cycle, so loads can be issued every
// cycle. A request (op 1) holds busy while the block table in a single-port
// RAM is scanned one entry per cycle and the chosen entry, if one fits, is
// written back. The result of every transaction appears on status and
// block_number in the single cycle in which done is high; they hold it until
// the next result, so capture it in that cycle.
`include "worst_fit_block_allocator_macros.svh"

module worst_fit_block_allocator #(
	parameter int MAX_BLOCKS = wfba_pkg::MAX_BLOCKS_DEF,
	parameter int SIZE_BITS  = wfba_pkg::SIZE_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic                          op,
	input  logic [wfba_pkg::AMOUNT_W-1:0] amount,
	output logic                          done,
	output logic [wfba_pkg::STATUS_W-1:0] status,
	output logic [wfba_pkg::NUM_W-1:0]    block_number
);

	import wfba_pkg::*;

	localparam int IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
	localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
	localparam int CMP_W = (SIZE_BITS > AMOUNT_W) ? SIZE_BITS : AMOUNT_W;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_WRITE
	} state_t;

	state_t                state_q;
	logic [CNT_W-1:0]      count_q;
	logic [CNT_W-1:0]      scan_q;
	logic [IDX_W-1:0]      idx_s1;
	logic                  vld_s1;
	logic [MAX_BLOCKS-1:0] taken_q;
	logic                  found_q;
	logic [IDX_W-1:0]      best_q;
	logic [SIZE_BITS-1:0]  best_rem_q;
	logic [CMP_W-1:0]      amt_q;

	logic                  accept;
	logic                  full;
	logic                  load_wr;
	logic                  ram_we;
	logic [IDX_W-1:0]      ram_addr;
	logic [SIZE_BITS-1:0]  ram_wdata;
	logic [SIZE_BITS-1:0]  ram_rdata;
	logic [CMP_W-1:0]      amt_in;
	logic [CMP_W-1:0]      size_ext;
	logic [CMP_W-1:0]      rem_ext;
	logic                  fit;
	logic                  better;
	logic [CNT_W-1:0]      count_inc;
	logic [CNT_W-1:0]      best_inc;
	logic [CNT_W+NUM_W-1:0] count_num;
	logic [CNT_W+NUM_W-1:0] best_num;

	assign busy      = (state_q != S_IDLE);
	assign accept    = start && !busy;
	assign full      = (count_q >= CNT_W'(MAX_BLOCKS));
	assign load_wr   = accept && (op == OP_LOAD) && !full;
	assign amt_in    = CMP_W'(amount);
	assign size_ext  = CMP_W'(ram_rdata);
	assign rem_ext   = size_ext - amt_q;
	assign fit       = vld_s1 && !taken_q[idx_s1] && (size_ext >= amt_q);
	assign better    = fit && (!found_q || (rem_ext[SIZE_BITS-1:0] > best_rem_q));
	assign count_inc = count_q + CNT_W'(1);
	assign best_inc  = CNT_W'(best_q) + CNT_W'(1);
	assign count_num = {{NUM_W{1'b0}}, count_inc};
	assign best_num  = {{NUM_W{1'b0}}, best_inc};

	always_comb begin
		ram_we    = 1'b0;
		ram_addr  = scan_q[IDX_W-1:0];
		ram_wdata = amt_in[SIZE_BITS-1:0];
		if (load_wr) begin
			ram_we   = 1'b1;
			ram_addr = count_q[IDX_W-1:0];
		end else if (state_q == S_WRITE && found_q) begin
			ram_we    = 1'b1;
			ram_addr  = best_q;
			ram_wdata = best_rem_q;
		end
	end

	wfba_ram #(
		.WIDTH(SIZE_BITS),
		.DEPTH(MAX_BLOCKS)
	) u_size_ram (
		.clk  (clk),
		.we   (ram_we),
		.addr (ram_addr),
		.wdata(ram_wdata),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk) begin
		if (accept) begin
			amt_q <= amt_in;
		end
		if (better) begin
			best_q     <= idx_s1;
			best_rem_q <= rem_ext[SIZE_BITS-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			count_q      <= '0;
			scan_q       <= '0;
			idx_s1       <= '0;
			vld_s1       <= 1'b0;
			taken_q      <= '0;
			found_q      <= 1'b0;
			done         <= 1'b0;
			status       <= ST_LOADED;
			block_number <= '0;
		end else begin
			done   <= 1'b0;
			vld_s1 <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (op == OP_REQUEST) begin
							state_q <= S_SCAN;
							scan_q  <= '0;
							found_q <= 1'b0;
						end else if (full) begin
							done         <= 1'b1;
							status       <= ST_FULL;
							block_number <= '0;
						end else begin
							taken_q[count_q[IDX_W-1:0]] <= 1'b0;
							count_q      <= count_inc;
							done         <= 1'b1;
							status       <= ST_LOADED;
							block_number <= count_num[NUM_W-1:0];
						end
					end
				end
				S_SCAN: begin
					if (better) begin
						found_q <= 1'b1;
					end
					if (scan_q == count_q) begin
						state_q <= S_WRITE;
					end else begin
						idx_s1 <= scan_q[IDX_W-1:0];
						vld_s1 <= 1'b1;
						scan_q <= scan_q + CNT_W'(1);
					end
				end
				S_WRITE: begin
					state_q <= S_IDLE;
					done    <= 1'b1;
					if (found_q) begin
						taken_q[best_q] <= 1'b1;
						status          <= ST_ALLOCATED;
						block_number    <= best_num[NUM_W-1:0];
					end else begin
						status       <= ST_NO_FIT;
						block_number <= '0;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	`WFBA_ASSERT_NEXT(a_req_goes_busy, accept && (op == OP_REQUEST), busy, "request did not start a scan")
	`WFBA_ASSERT_NEXT(a_load_answers, accept && (op == OP_LOAD), done, "load gave no result")
	`WFBA_ASSERT_SAME(a_done_idle, done, !busy, "result shown while busy")
	`WFBA_ASSERT_SAME(a_count_bound, 1'b1, count_q <= CNT_W'(MAX_BLOCKS), "block count overflow")
	`WFBA_ASSERT_SAME(a_scan_bound, state_q == S_SCAN, scan_q <= count_q, "scan ran past loaded blocks")

endmodule
